FILE: sv/assert_macros.svh
// Assertion macros shared by the voice RTL.
// Each macro expands to one labelled concurrent assertion, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Require a consequent in the same cycle as an antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Require a consequent in the cycle after an antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tve_pkg.sv
// Constants for the triangle voice: register map, pitch table, envelope format.
// No dependencies; used by triangle_voice_envelope.
package tve_pkg;

    localparam int LEN_W   = 24;
    localparam int LEVEL_W = 16;
    localparam int POS_W   = 26;
    localparam int NOTE_W  = 7;
    localparam int OUT_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes, at byte address 4*index
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_HOLD    = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_LEVEL   = 2'd3;

    localparam logic [LEN_W-1:0]   ATTACK_RST  = 24'd1500;
    localparam logic [LEN_W-1:0]   HOLD_RST    = 24'd0;
    localparam logic [LEN_W-1:0]   RELEASE_RST = 24'd25500;
    localparam logic [LEVEL_W-1:0] LEVEL_RST   = 16'd32768;

    // commands
    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // pitch
    localparam int          A4_HZ       = 440;
    localparam logic [8:0]  NOTE_OFFSET = 9'd60;
    localparam logic [4:0]  OCT_BIAS    = 5'd10;
    localparam logic [18:0] DIV12_RECIP = 19'd683;
    localparam int          DIV12_SHIFT = 13;
    localparam int          SEMI_COUNT  = 12;
    localparam int          SEMI_FRAC   = 30;

    localparam logic [31:0] SEMITONE_Q30 [SEMI_COUNT] = '{
        32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
        32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
        32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
    };

    // envelope: unsigned Q.15, attack carries a small floor
    localparam int             ENV_FRAC   = 15;
    localparam logic [15:0]    ENV_OFFSET = 16'd328;
    localparam int             WAVE_W     = 17;

endpackage

FILE: sv/triangle_voice_envelope.sv
// Triangle voice with attack/hold/release envelope: top level.
// Depends on tve_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per command.
//   A trigger (i_command = 0) loads the note's phase step and start delay and
//   rearms the envelope; it gives no result.
//   A tick (i_command = 1) gives exactly one result on the output channel
//   (o_valid / i_stall): o_sample, signed Q1.15, and o_sounding.
//   From acceptance to o_valid, a silent tick (no note, start delay running,
//   voice ended) goes straight to the output step; an ended envelope found
//   with the voice still armed passes the total and select steps first; a
//   sounding tick in attack or release adds the shared restoring divider (one
//   quotient bit per cycle), then wave, multiply, saturate; hold skips it.
//   o_stall is low only while the sequencer is idle, so one tick is in work at
//   a time; the output register lets the next transaction enter while a result
//   still waits. If the receiver stalls, the sequencer holds in its last step
//   until the output register frees.
//   Reset (synchronous, i_rst_n low) loads the register defaults, silences the
//   voice and clears the phase and phase step.
//   The APB-style port holds four registers at byte addresses 0, 4, 8, 12;
//   write them only while the block is idle.
`include "assert_macros.svh"

module triangle_voice_envelope #(
    parameter int SAMPLE_RATE = 44100,
    parameter int NOTE_COUNT  = 128,
    parameter int PHASE_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic [tve_pkg::LEN_W-1:0]    i_start_delay,
    input  logic [tve_pkg::NOTE_W-1:0]   i_note,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [tve_pkg::OUT_W-1:0] o_sample,
    output logic                         o_sounding,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tve_pkg::ADDR_W-1:0]   paddr,
    input  logic [tve_pkg::DATA_W-1:0]   pwdata,
    output logic [tve_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int LW = tve_pkg::LEN_W;
    localparam int PW = tve_pkg::POS_W;

    localparam logic [63:0] BASE_STEP =
        (64'(tve_pkg::A4_HZ) << PHASE_BITS) / 64'(SAMPLE_RATE);

    function automatic logic [tve_pkg::SEMI_COUNT-1:0][PHASE_BITS-1:0] build_semi_steps();
        logic [tve_pkg::SEMI_COUNT-1:0][PHASE_BITS-1:0] tab;
        logic [127:0]                                   prod;
        for (int k = 0; k < tve_pkg::SEMI_COUNT; k++) begin
            prod   = 128'(BASE_STEP) * 128'(tve_pkg::SEMITONE_Q30[k]);
            tab[k] = PHASE_BITS'(prod >> tve_pkg::SEMI_FRAC);
        end
        return tab;
    endfunction

    localparam logic [tve_pkg::SEMI_COUNT-1:0][PHASE_BITS-1:0] SEMI_STEP = build_semi_steps();

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOT  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAVE = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_SAT  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]              r_state, n_state;

    logic [LW-1:0]           r_attack, r_hold, r_release;
    logic [tve_pkg::LEVEL_W-1:0] r_level;

    logic                    r_act;
    logic [LW-1:0]           r_delay;
    logic [PW-1:0]           r_pos;
    logic [PHASE_BITS-1:0]   r_phase, r_step;
    logic [3:0]              r_cnt;

    logic [PW-1:0]           r_ah, r_tot;
    logic [LW-1:0]           r_rem, r_div;
    logic [15:0]             r_quo, r_env;
    logic                    r_atk;
    logic signed [tve_pkg::WAVE_W-1:0] r_wave;
    logic signed [33:0]      r_prod;
    logic signed [tve_pkg::OUT_W-1:0] r_res_sample, r_osample;
    logic                    r_res_snd, r_osnd, r_oval;

    logic                    in_acc, cfg_wr, out_load;

    // trigger: note to phase step
    logic [8:0]              note_c, note_t, semi_t;
    logic [18:0]             oct_prod;
    logic [4:0]              oct_q;
    logic [3:0]              semi;
    logic [PHASE_BITS-1:0]   semi_val, n_step;

    // divider step
    logic [LW:0]             div_trial, div_diff;
    logic                    div_ge;
    logic [15:0]             quo_next;

    // triangle and saturation
    logic [PHASE_BITS+16:0]  phase_ext;
    logic [16:0]             wave_u;
    logic signed [17:0]      wave_full;
    logic signed [18:0]      prod_q;
    logic signed [tve_pkg::OUT_W-1:0] sat_q;
    logic [PW-1:0]           pos_inc;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_load = (r_state == S_OUT) && (!r_oval || !i_stall);

    assign o_valid    = r_oval;
    assign o_sample   = r_osample;
    assign o_sounding = r_osnd;

    always_comb begin
        case (paddr[3:2])
            tve_pkg::REG_ATTACK:  prdata = 32'(r_attack);
            tve_pkg::REG_HOLD:    prdata = 32'(r_hold);
            tve_pkg::REG_RELEASE: prdata = 32'(r_release);
            tve_pkg::REG_LEVEL:   prdata = 32'(r_level);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        if ({2'b00, i_note} >= 9'(NOTE_COUNT)) begin
            note_c = 9'(NOTE_COUNT - 1);
        end else begin
            note_c = {2'b00, i_note};
        end
        note_t   = note_c + tve_pkg::NOTE_OFFSET;
        oct_prod = 19'(note_t) * tve_pkg::DIV12_RECIP;
        oct_q    = oct_prod[tve_pkg::DIV12_SHIFT +: 5];
        semi_t   = note_t - (9'({oct_q, 3'b000}) + 9'({oct_q, 2'b00}));
        semi     = semi_t[3:0];
        semi_val = SEMI_STEP[semi];
        if (oct_q >= tve_pkg::OCT_BIAS) begin
            n_step = semi_val << (oct_q - tve_pkg::OCT_BIAS);
        end else begin
            n_step = semi_val >> (tve_pkg::OCT_BIAS - oct_q);
        end
    end

    always_comb begin
        div_trial = (r_cnt == 4'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        div_ge    = (div_trial >= {1'b0, r_div});
        div_diff  = div_trial - {1'b0, r_div};
        quo_next  = {r_quo[14:0], div_ge};
    end

    always_comb begin
        phase_ext = {r_phase, 17'd0};
        wave_u    = phase_ext[PHASE_BITS+16 -: 17];
        if (!wave_u[16]) begin
            wave_full = $signed({1'b0, wave_u}) - 18'sd32768;
        end else begin
            wave_full = 18'sd98304 - $signed({1'b0, wave_u});
        end
        prod_q = r_prod[33:tve_pkg::ENV_FRAC];
        if (prod_q[18:15] == 4'b0000 || prod_q[18:15] == 4'b1111) begin
            sat_q = prod_q[15:0];
        end else if (prod_q[18]) begin
            sat_q = 16'sh8000;
        end else begin
            sat_q = 16'sh7FFF;
        end
        pos_inc = r_pos + 26'd1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_command == tve_pkg::CMD_TICK) begin
                    n_state = (r_act && r_delay == '0) ? S_TOT : S_OUT;
                end
            end
            S_TOT: n_state = S_SEL;
            S_SEL: begin
                if (r_pos >= r_tot) begin
                    n_state = S_OUT;
                end else if (r_pos < PW'(r_attack) || r_pos >= r_ah) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WAVE;
                end
            end
            S_DIV:  n_state = (r_cnt == 4'd15) ? S_WAVE : S_DIV;
            S_WAVE: n_state = S_MUL;
            S_MUL:  n_state = S_SAT;
            S_SAT:  n_state = S_OUT;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_attack  <= tve_pkg::ATTACK_RST;
            r_hold    <= tve_pkg::HOLD_RST;
            r_release <= tve_pkg::RELEASE_RST;
            r_level   <= tve_pkg::LEVEL_RST;
            r_act     <= 1'b0;
            r_delay   <= '0;
            r_pos     <= '0;
            r_phase   <= '0;
            r_step    <= '0;
            r_cnt     <= '0;
            r_oval    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    tve_pkg::REG_ATTACK:  r_attack  <= pwdata[LW-1:0];
                    tve_pkg::REG_HOLD:    r_hold    <= pwdata[LW-1:0];
                    tve_pkg::REG_RELEASE: r_release <= pwdata[LW-1:0];
                    tve_pkg::REG_LEVEL:   r_level   <= pwdata[tve_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_command == tve_pkg::CMD_TRIGGER) begin
                            r_step  <= n_step;
                            r_delay <= i_start_delay;
                            r_pos   <= '0;
                            r_act   <= 1'b1;
                        end else if (r_act && r_delay != '0) begin
                            r_delay <= r_delay - 24'd1;
                        end
                    end
                end
                S_SEL: begin
                    r_cnt <= '0;
                    if (r_pos >= r_tot) begin
                        r_act <= 1'b0;
                    end else begin
                        r_phase <= r_phase + r_step;
                    end
                end
                S_DIV: r_cnt <= r_cnt + 4'd1;
                S_SAT: begin
                    r_pos <= pos_inc;
                    if (pos_inc >= r_tot) begin
                        r_act <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ah         <= PW'(r_attack) + PW'(r_hold);
                r_res_sample <= '0;
                r_res_snd    <= 1'b0;
            end
            S_TOT: r_tot <= r_ah + PW'(r_release);
            S_SEL: begin
                r_res_sample <= '0;
                r_res_snd    <= 1'b0;
                if (r_pos < PW'(r_attack)) begin
                    r_rem <= r_pos[LW-1:0];
                    r_div <= r_attack;
                    r_atk <= 1'b1;
                end else if (r_pos < r_ah) begin
                    r_env <= r_level;
                end else begin
                    r_rem <= LW'(r_tot - r_pos);
                    r_div <= r_release;
                    r_atk <= 1'b0;
                end
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[LW-1:0] : div_trial[LW-1:0];
                r_quo <= quo_next;
                if (r_cnt == 4'd15) begin
                    r_env <= quo_next + (r_atk ? tve_pkg::ENV_OFFSET : 16'd0);
                end
            end
            S_WAVE: r_wave <= wave_full[tve_pkg::WAVE_W-1:0];
            S_MUL:  r_prod <= r_wave * $signed({1'b0, r_env});
            S_SAT: begin
                r_res_sample <= sat_q;
                r_res_snd    <= 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_osample <= r_res_sample;
            r_osnd    <= r_res_snd;
        end
    end

    `ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div != '0, "divide by zero")
    `ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n, r_state == S_DIV && r_cnt != 4'd0, r_rem < r_div, "divider remainder out of range")
    `ASSERT_IMPLY(a_sel_live, i_clk, i_rst_n, r_state == S_SEL, r_act && r_delay == '0, "envelope evaluated while silent")
    `ASSERT_NEXT(a_pos_end, i_clk, i_rst_n, r_state == S_SAT, !r_act || r_pos < r_tot, "voice left active past envelope end")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for triangle_voice_envelope: note/tick transactions in, samples out.
// Predicts every sample from its own voice and envelope arithmetic; needs tve_pkg and the RTL.
module tb_top;

    localparam int LEN_W   = tve_pkg::LEN_W;
    localparam int NOTE_W  = tve_pkg::NOTE_W;
    localparam int OUT_W   = tve_pkg::OUT_W;
    localparam int POS_W   = tve_pkg::POS_W;
    localparam int LEVEL_W = tve_pkg::LEVEL_W;
    localparam int ADDR_W  = tve_pkg::ADDR_W;
    localparam int DATA_W  = tve_pkg::DATA_W;

    localparam int VOICE_RATE     = 44100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic              command;
        logic [LEN_W-1:0]  delay;
        logic [NOTE_W-1:0] note;
    } t_voice_cmd;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    sounding;
    } t_voice_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_command = tve_pkg::CMD_TRIGGER;
    logic [LEN_W-1:0]  i_start_delay = '0;
    logic [NOTE_W-1:0] i_note = '0;

    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_sample;
    logic                    o_sounding;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    triangle_voice_envelope dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_start_delay (i_start_delay),
        .i_note        (i_note),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .o_sounding    (o_sounding),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register mirror
    logic [LEN_W-1:0]   env_attack  = tve_pkg::ATTACK_RST;
    logic [LEN_W-1:0]   env_hold    = tve_pkg::HOLD_RST;
    logic [LEN_W-1:0]   env_release = tve_pkg::RELEASE_RST;
    logic [LEVEL_W-1:0] env_level   = tve_pkg::LEVEL_RST;

    // voice state
    logic [LEN_W-1:0] voice_delay = '0;
    logic [POS_W-1:0] voice_pos = '0;
    logic             voice_on = 1'b0;
    logic [31:0]      osc_phase = '0;
    logic [31:0]      osc_step = '0;

    t_voice_cmd    note_cmds[$];
    t_voice_sample pending_samples[$];

    t_voice_cmd    next_cmd;
    t_voice_sample want;
    int  fail_count = 0;
    bit  calm_tail = 1'b0;
    int  send_gap = 0, send_steady = 0;
    int  recv_burst = 0, recv_steady = 0;
    int  results_seen = 0, hold_off_left = 0;
    bit  pressure_done = 1'b0;
    int  idle_cycles = 0;

    function automatic logic [31:0] note_step(input logic [NOTE_W-1:0] note);
        int t, oct, semi;
        logic [63:0] base, s;
        t = int'(note) + 60;
        oct = t / 12 - 10;
        semi = t % 12;
        base = (64'(tve_pkg::A4_HZ) << 32) / 64'(VOICE_RATE);
        s = (base * 64'(tve_pkg::SEMITONE_Q30[semi])) >> tve_pkg::SEMI_FRAC;
        if (oct >= 0) begin
            s = s << oct;
        end else begin
            s = s >> (-oct);
        end
        return s[31:0];
    endfunction

    task voice_advance(input logic command, input logic [LEN_W-1:0] delay,
                       input logic [NOTE_W-1:0] note);
        longint a, h, r, p, env, total, prod, q;
        int wave;
        logic [tve_pkg::WAVE_W-1:0] u;
        t_voice_sample res;
        if (command == tve_pkg::CMD_TRIGGER) begin
            osc_step = note_step(note);
            voice_delay = delay;
            voice_pos = '0;
            voice_on = 1'b1;
            return;
        end
        res.sample = '0;
        res.sounding = 1'b0;
        if (voice_on) begin
            if (voice_delay != 0) begin
                voice_delay = voice_delay - 1'b1;
            end else begin
                a = env_attack;
                h = env_hold;
                r = env_release;
                p = voice_pos;
                total = a + h + r;
                if (p >= total) begin
                    voice_on = 1'b0;
                end else begin
                    if (p < a) begin
                        env = (p * 32768) / a + tve_pkg::ENV_OFFSET;
                    end else if (p < a + h) begin
                        env = env_level;
                    end else begin
                        env = ((r - (p - a - h)) * 32768) / r;
                    end
                    osc_phase = osc_phase + osc_step;
                    u = osc_phase[31:15];
                    wave = u[16] ? 98304 - int'(u) : int'(u) - 32768;
                    prod = longint'(wave) * env;
                    q = prod >>> tve_pkg::ENV_FRAC;
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    res.sample = q[OUT_W-1:0];
                    res.sounding = 1'b1;
                    voice_pos = POS_W'(p + 1);
                    if (longint'(voice_pos) >= total) voice_on = 1'b0;
                end
            end
        end
        pending_samples.push_back(res);
    endtask

    task flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
            send_steady = 0;
        end else begin
            if (i_valid && !o_stall) voice_advance(i_command, i_start_delay, i_note);
            if (send_steady > 0) send_steady--;
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (note_cmds.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!calm_tail && send_steady == 0 && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else begin
                    if (!calm_tail && send_steady == 0 && $urandom_range(0, 40) == 0)
                        send_steady = $urandom_range(20, 120);
                    next_cmd = note_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_command <= next_cmd.command;
                    i_start_delay <= next_cmd.delay;
                    i_note <= next_cmd.note;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_samples.size() == 0) begin
                    flag_mismatch($sformatf("unexpected sample %0d sounding %0b",
                                            o_sample, o_sounding));
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample !== want.sample)
                        flag_mismatch($sformatf("sample %0d, expected %0d",
                                                o_sample, want.sample));
                    if (o_sounding !== want.sounding)
                        flag_mismatch($sformatf("sounding %0b, expected %0b",
                                                o_sounding, want.sounding));
                end
            end
            if (recv_steady > 0) recv_steady--;
            if (!pressure_done && results_seen >= 250) begin
                pressure_done = 1'b1;
                hold_off_left = HOLD_OFF_LEN;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_stall <= 1'b1;
            end else if (recv_burst > 0) begin
                recv_burst--;
                i_stall <= 1'b1;
            end else if (calm_tail || recv_steady > 0) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                recv_burst = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 40) == 0) recv_steady = $urandom_range(20, 120);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tve_pkg::REG_ATTACK:  env_attack = val[LEN_W-1:0];
            tve_pkg::REG_HOLD:    env_hold = val[LEN_W-1:0];
            tve_pkg::REG_RELEASE: env_release = val[LEN_W-1:0];
            tve_pkg::REG_LEVEL:   env_level = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task configure(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] h,
                   input logic [LEN_W-1:0] r, input logic [LEVEL_W-1:0] lvl);
        cfg_write(tve_pkg::REG_ATTACK, DATA_W'(a));
        cfg_write(tve_pkg::REG_HOLD, DATA_W'(h));
        cfg_write(tve_pkg::REG_RELEASE, DATA_W'(r));
        cfg_write(tve_pkg::REG_LEVEL, DATA_W'(lvl));
        @(negedge i_clk);
    endtask

    // wait out every pending transaction, then let trailing triggers finish
    task settle();
        @(negedge i_clk);
        while (note_cmds.size() != 0 || i_valid || pending_samples.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task push_trigger(input logic [LEN_W-1:0] delay, input logic [NOTE_W-1:0] note);
        t_voice_cmd c;
        c.command = tve_pkg::CMD_TRIGGER;
        c.delay = delay;
        c.note = note;
        note_cmds.push_back(c);
    endtask

    task push_ticks(input int n);
        t_voice_cmd c;
        c.command = tve_pkg::CMD_TICK;
        c.delay = LEN_W'($urandom());
        c.note = NOTE_W'($urandom());
        repeat (n) note_cmds.push_back(c);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_MAX;
            2: return LEN_W'($urandom());
            default: return LEN_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return tve_pkg::LEVEL_RST;
            default: return LEVEL_W'($urandom());
        endcase
    endfunction

    // mostly notes with random content (whole when short enough), some stray ticks and cut-short notes
    task queue_note_runs(input int n);
        int made, kind, span, dly;
        longint total;
        made = 0;
        total = longint'(env_attack) + env_hold + env_release;
        while (made < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                dly = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                  : $urandom_range(0, 3);
                push_trigger(LEN_W'(dly), NOTE_W'($urandom_range(0, 127)));
                if (total + dly + 3 > 60) begin
                    span = $urandom_range(1, 60);
                end else begin
                    span = int'(total) + dly + $urandom_range(0, 3);
                end
                push_ticks(span);
                made += span + 1;
            end else if (kind == 7) begin
                span = $urandom_range(1, 5);
                push_ticks(span);
                made += span;
            end else begin
                push_trigger(LEN_W'($urandom_range(0, 2)), NOTE_W'($urandom_range(0, 127)));
                span = $urandom_range(1, 4);
                push_ticks(span);
                made += span + 1;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: tick before any note, start delay, note and delay extremes
        push_ticks(1);
        push_trigger(24'd2, 7'd60);
        push_ticks(3);
        push_trigger(24'd0, 7'd0);
        push_ticks(1);
        push_trigger(LEN_MAX, 7'd127);
        push_ticks(1);
        push_trigger(24'd0, 7'd127);
        push_ticks(1);
        settle();

        // empty attack, full-scale hold level to saturate, end of envelope
        configure(24'd0, 24'd2, 24'd3, 16'hFFFF);
        push_trigger(24'd1, 7'd72);
        push_ticks(7);
        settle();

        // empty release, silent hold
        configure(24'd3, 24'd2, 24'd0, 16'd0);
        push_trigger(24'd0, 7'd48);
        push_ticks(6);
        settle();

        configure(LEN_MAX, LEN_MAX, LEN_MAX, tve_pkg::LEVEL_RST);
        push_trigger(24'd0, 7'd100);
        push_ticks(2);
        settle();

        repeat (8) begin
            configure(pick_len(), pick_len(), pick_len(), pick_level());
            queue_note_runs(130);
            settle();
        end

        configure(LEN_W'($urandom_range(1, 8)), LEN_W'($urandom_range(0, 4)),
                  LEN_W'($urandom_range(1, 8)), pick_level());
        calm_tail = 1'b1;
        queue_note_runs(170);
        settle();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tve_pkg.sv
sv/triangle_voice_envelope.sv
tb/tb_top.sv
